// File: sv/stack_queue_transfer_engine_macros.svh
// ----------------------------------------------------------------------------
// Stack/queue transfer engine assertion macros
// Shorthand for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef STACK_QUEUE_TRANSFER_ENGINE_MACROS_SVH
`define STACK_QUEUE_TRANSFER_ENGINE_MACROS_SVH

// same-cycle implication
`define SQTE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SQTE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/sqte_pkg.sv
// ----------------------------------------------------------------------------
// sqte_pkg
// Shared types, codes and defaults for the stack/queue transfer engine.
// ----------------------------------------------------------------------------
package sqte_pkg;

   localparam int STACK_DEPTH_DEF = 32;
   localparam int QUEUE_DEPTH_DEF = 32;
   localparam int WORD_WIDTH_DEF  = 32;

   localparam int REQ_TYPE_W = 3;
   localparam int IO_WORD_W  = 32;
   localparam int STATUS_W   = 2;

   localparam logic [REQ_TYPE_W-1:0] REQ_PUSH    = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_POP     = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_ENQUEUE = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_DEQUEUE = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_POUR    = 3'd4;
   localparam logic [REQ_TYPE_W-1:0] REQ_DUMP    = 3'd5;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 2'd0,
      ST_EMPTY      = 2'd1,
      ST_FULL       = 2'd2,
      ST_DUMP_EMPTY = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POUR_RD,
      S_POUR_WR,
      S_DUMP_RD,
      S_DUMP_WR
   } state_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic       enq;
      logic       deq;
      logic       pour_rd;
      logic       pour_mv;
      logic       dump_start;
      logic       dump_rd;
      logic       dump_next;
      logic       out_load;
      logic       out_dump;
      logic       out_last;
      status_type out_status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic stack_empty;
      logic stack_full;
      logic queue_empty;
      logic queue_full;
      logic dump_last;
      logic out_free;
   } dp_stat_type;

endpackage

// File: sv/sqte_ram.sv
// ----------------------------------------------------------------------------
// sqte_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sqte_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/sqte_ctrl.sv
// ----------------------------------------------------------------------------
// sqte_ctrl
// Request sequencer: decodes requests and steps the pour and dump walks.
// ----------------------------------------------------------------------------
module sqte_ctrl
   import sqte_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_TYPE_W-1:0] req_type,
   input  dp_stat_type           stat,
   output ctrl_cmd_type          cmd
);

   state_type state_ff;
   state_type state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // only looked at in idle, where ready follows out_free
   assign accept = req_tvalid && stat.out_free;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.out_status = ST_OK;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = stat.out_free;
            if (accept) begin
               unique case (req_type)
                  REQ_PUSH: begin
                     cmd.out_load = 1'b1;
                     cmd.out_last = 1'b1;
                     if (stat.stack_full) begin
                        cmd.out_status = ST_FULL;
                     end else begin
                        cmd.push = 1'b1;
                     end
                  end
                  REQ_POP: begin
                     cmd.out_load = 1'b1;
                     cmd.out_last = 1'b1;
                     if (stat.stack_empty) begin
                        cmd.out_status = ST_EMPTY;
                     end else begin
                        cmd.pop = 1'b1;
                     end
                  end
                  REQ_ENQUEUE: begin
                     cmd.out_load = 1'b1;
                     cmd.out_last = 1'b1;
                     if (stat.queue_full) begin
                        cmd.out_status = ST_FULL;
                     end else begin
                        cmd.enq = 1'b1;
                     end
                  end
                  REQ_DEQUEUE: begin
                     cmd.out_load = 1'b1;
                     cmd.out_last = 1'b1;
                     if (stat.queue_empty) begin
                        cmd.out_status = ST_EMPTY;
                     end else begin
                        cmd.deq = 1'b1;
                     end
                  end
                  REQ_POUR: begin
                     state_in = S_POUR_RD;
                  end
                  REQ_DUMP: begin
                     if (stat.queue_empty) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_last   = 1'b1;
                        cmd.out_status = ST_DUMP_EMPTY;
                     end else begin
                        cmd.dump_start = 1'b1;
                        state_in       = S_DUMP_RD;
                     end
                  end
                  default: begin
                     cmd.out_load = 1'b1;
                     cmd.out_last = 1'b1;
                  end
               endcase
            end
         end
         S_POUR_RD: begin
            if (!stat.stack_empty && !stat.queue_full) begin
               cmd.pour_rd = 1'b1;
               state_in    = S_POUR_WR;
            end else if (stat.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_last   = 1'b1;
               cmd.out_status = stat.stack_empty ? ST_OK : ST_FULL;
               state_in       = S_IDLE;
            end
         end
         S_POUR_WR: begin
            cmd.pour_mv = 1'b1;
            state_in    = S_POUR_RD;
         end
         S_DUMP_RD: begin
            cmd.dump_rd = 1'b1;
            state_in    = S_DUMP_WR;
         end
         S_DUMP_WR: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_dump = 1'b1;
               cmd.out_last = stat.dump_last;
               if (stat.dump_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.dump_next = 1'b1;
                  state_in      = S_DUMP_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: sv/sqte_dp.sv
// ----------------------------------------------------------------------------
// sqte_dp
// Stack and queue storage, occupancy counters, queue pointers and the
// response register.
// ----------------------------------------------------------------------------
module sqte_dp
   import sqte_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int WORD_WIDTH  = WORD_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [IO_WORD_W-1:0] req_word,
   input  ctrl_cmd_type         cmd,
   output dp_stat_type          stat,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output logic [IO_WORD_W-1:0] rsp_word,
   output logic                 rsp_last,
   output status_type           rsp_status
);

   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int SCW = $clog2(STACK_DEPTH + 1);
   localparam int QAW = $clog2(QUEUE_DEPTH);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);
   localparam int QSW = QCW + 1;

   logic [SCW-1:0]        stack_count_ff, stack_count_in;
   logic [QAW-1:0]        queue_head_ff, queue_head_in;
   logic [QCW-1:0]        queue_count_ff, queue_count_in;
   logic [QCW-1:0]        dump_idx_ff, dump_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IO_WORD_W-1:0]  rsp_word_ff;
   logic                  rsp_last_ff;
   status_type            rsp_status_ff;

   logic [WORD_WIDTH-1:0] word_st;
   logic [WORD_WIDTH-1:0] stack_rd_data;
   logic [WORD_WIDTH-1:0] queue_rd_data;
   logic [WORD_WIDTH-1:0] queue_wr_data;
   logic [IO_WORD_W-1:0]  dump_word;
   logic [SCW-1:0]        stack_top;
   logic [QSW-1:0]        tail_sum, tail_wrap;
   logic [QSW-1:0]        rd_sum, rd_wrap;
   logic [QAW-1:0]        tail_addr, rd_addr;
   logic [QSW-1:0]        head_inc;
   logic                  out_free;

   generate
      if (WORD_WIDTH <= IO_WORD_W) begin : g_in_narrow
         assign word_st = req_word[WORD_WIDTH-1:0];
      end else begin : g_in_wide
         assign word_st = {{(WORD_WIDTH-IO_WORD_W){req_word[IO_WORD_W-1]}}, req_word};
      end
      if (WORD_WIDTH >= IO_WORD_W) begin : g_out_wide
         assign dump_word = queue_rd_data[IO_WORD_W-1:0];
      end else begin : g_out_narrow
         assign dump_word = {{(IO_WORD_W-WORD_WIDTH){1'b0}}, queue_rd_data};
      end
   endgenerate

   // circular slot = (head + offset) mod depth, offset never above depth
   assign tail_sum  = QSW'(queue_head_ff) + QSW'(queue_count_ff);
   assign tail_wrap = (tail_sum >= QSW'(QUEUE_DEPTH)) ? tail_sum - QSW'(QUEUE_DEPTH) : tail_sum;
   assign tail_addr = tail_wrap[QAW-1:0];
   assign rd_sum    = QSW'(queue_head_ff) + QSW'(dump_idx_in);
   assign rd_wrap   = (rd_sum >= QSW'(QUEUE_DEPTH)) ? rd_sum - QSW'(QUEUE_DEPTH) : rd_sum;
   assign rd_addr   = rd_wrap[QAW-1:0];
   assign head_inc  = QSW'(queue_head_ff) + QSW'(1);
   assign stack_top = stack_count_ff - SCW'(1);

   assign queue_wr_data = cmd.pour_mv ? stack_rd_data : word_st;

   sqte_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (stack_count_ff[SAW-1:0]),
      .wr_data (word_st),
      .rd_en   (cmd.pour_rd),
      .rd_addr (stack_top[SAW-1:0]),
      .rd_data (stack_rd_data)
   );

   sqte_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (cmd.enq || cmd.pour_mv),
      .wr_addr (tail_addr),
      .wr_data (queue_wr_data),
      .rd_en   (cmd.dump_rd),
      .rd_addr (rd_addr),
      .rd_data (queue_rd_data)
   );

   always_comb begin
      stack_count_in = stack_count_ff;
      queue_head_in  = queue_head_ff;
      queue_count_in = queue_count_ff;
      dump_idx_in    = dump_idx_ff;
      if (cmd.push) begin
         stack_count_in = stack_count_ff + SCW'(1);
      end else if (cmd.pop || cmd.pour_mv) begin
         stack_count_in = stack_count_ff - SCW'(1);
      end
      if (cmd.enq || cmd.pour_mv) begin
         queue_count_in = queue_count_ff + QCW'(1);
      end else if (cmd.deq) begin
         queue_count_in = queue_count_ff - QCW'(1);
         queue_head_in  = (head_inc == QSW'(QUEUE_DEPTH)) ? '0 : head_inc[QAW-1:0];
      end
      if (cmd.dump_start) begin
         dump_idx_in = '0;
      end else if (cmd.dump_next) begin
         dump_idx_in = dump_idx_ff + QCW'(1);
      end
   end

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stack_count_ff <= '0;
         queue_head_ff  <= '0;
         queue_count_ff <= '0;
         dump_idx_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stack_count_ff <= stack_count_in;
         queue_head_ff  <= queue_head_in;
         queue_count_ff <= queue_count_in;
         dump_idx_ff    <= dump_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_word_ff   <= cmd.out_dump ? dump_word : '0;
         rsp_last_ff   <= cmd.out_last;
         rsp_status_ff <= cmd.out_status;
      end
   end

   assign stat.stack_empty = (stack_count_ff == '0);
   assign stat.stack_full  = (stack_count_ff == SCW'(STACK_DEPTH));
   assign stat.queue_empty = (queue_count_ff == '0);
   assign stat.queue_full  = (queue_count_ff == QCW'(QUEUE_DEPTH));
   assign stat.dump_last   = ((dump_idx_ff + QCW'(1)) == queue_count_ff);
   assign stat.out_free    = out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// File: sv/stack_queue_transfer_engine.sv
// ----------------------------------------------------------------------------
// stack_queue_transfer_engine
// Bounded LIFO stack and FIFO queue with push/pop/enqueue/dequeue, a
// stack-to-queue pour and a queue dump.
//
//   channel  dir  tdata              tuser            tlast
//   req_     in   [31:0] word_in     [2:0] req_type   -
//   rsp_     out  [31:0] word_out    [1:0] status     last
//
// Push, pop, enqueue, dequeue, unused codes: result loaded at the accepting edge.
// Pour: each word moved takes a stack RAM read, then a queue RAM write; the result is issued after the last move.
// Dump: each word takes a registered queue RAM read, then a response load, after the accepting edge.
// Reset clears the counters and head pointer; the RAMs are not cleared.
// A stalled response holds each response load; requests are taken in idle only.
// ----------------------------------------------------------------------------
module stack_queue_transfer_engine
   import sqte_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int WORD_WIDTH  = WORD_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] word_in
   input  logic [2:0]  req_tuser,   // [2:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] word_out
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;
   status_type   rsp_status;

   sqte_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_type   (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   sqte_dp #(
      .STACK_DEPTH (STACK_DEPTH),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .WORD_WIDTH  (WORD_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_word   (rsp_tdata),
      .rsp_last   (rsp_tlast),
      .rsp_status (rsp_status)
   );

   assign rsp_tuser = rsp_status;

endmodule

// File: sv/sqte_checker.sv
// ----------------------------------------------------------------------------
// sqte_checker
// Port-level checks for the stack/queue transfer engine, bound to the top.
// ----------------------------------------------------------------------------
`include "stack_queue_transfer_engine_macros.svh"

module sqte_checker
   import sqte_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [1:0]  rsp_tuser
);

   logic rsp_stall;
   logic dump_empty;
   logic mid_dump;
   logic word_seen;

   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign dump_empty = rsp_tvalid && (rsp_tuser == ST_DUMP_EMPTY);
   assign mid_dump   = rsp_tvalid && !rsp_tlast;
   assign word_seen  = rsp_tvalid && (rsp_tdata != '0);

   `SQTE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "stalled transfer changed")
   `SQTE_ASSERT_NOW(a_dump_empty_shape, clock, reset, dump_empty, rsp_tlast && (rsp_tdata == '0), "empty dump result malformed")
   `SQTE_ASSERT_NOW(a_word_only_ok, clock, reset, word_seen, rsp_tuser == ST_OK, "data word with error status")
   `SQTE_ASSERT_NOW(a_busy_mid_dump, clock, reset, mid_dump, !req_tready && (rsp_tuser == ST_OK), "request taken during dump")

endmodule

bind stack_queue_transfer_engine sqte_checker u_sqte_checker (.*);

// File: verif/sqte_shadow_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqte_shadow_checker
// Watches both streams of the stack/queue transfer engine. It keeps a shadow
// stack and a shadow circular queue, builds the expected responses from every
// accepted request, and compares each response transfer field by field.
// ----------------------------------------------------------------------------
module sqte_shadow_checker
   import sqte_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] word_in
   input  logic [2:0]  req_tuser,   // [2:0] req_type
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [31:0] word_out
   input  logic        rsp_tlast,
   input  logic [1:0]  rsp_tuser,   // [1:0] status
   output int          fail_count,
   output int          pending,
   output int          rsp_seen
);

   typedef struct {
      logic [31:0] word;
      logic        last;
      status_type  status;
   } rsp_item_type;

   rsp_item_type awaited_rsp[$];
   logic [31:0]  stack_mem [STACK_DEPTH_DEF];
   logic [31:0]  queue_mem [QUEUE_DEPTH_DEF];
   int           stack_fill;
   int           queue_fill;
   int           queue_head;
   int           errs = 0;
   int           seen = 0;

   assign fail_count = errs;
   assign rsp_seen   = seen;

   function automatic void await_rsp(logic [31:0] word, logic last, status_type status);
      rsp_item_type item;
      item.word   = word;
      item.last   = last;
      item.status = status;
      awaited_rsp.push_back(item);
   endfunction

   function automatic bit queue_put(logic [31:0] word);
      if (queue_fill >= QUEUE_DEPTH_DEF)
         return 1'b0;
      queue_mem[(queue_head + queue_fill) % QUEUE_DEPTH_DEF] = word;
      queue_fill++;
      return 1'b1;
   endfunction

   function automatic void apply_request(logic [2:0] kind, logic [31:0] word);
      status_type st;
      st = ST_OK;
      if (kind == REQ_DUMP) begin
         if (queue_fill == 0)
            await_rsp('0, 1'b1, ST_DUMP_EMPTY);
         else
            for (int i = 0; i < queue_fill; i++)
               await_rsp(queue_mem[(queue_head + i) % QUEUE_DEPTH_DEF],
                         i == queue_fill - 1, ST_OK);
      end else begin
         case (kind)
            REQ_PUSH: begin
               if (stack_fill < STACK_DEPTH_DEF) begin
                  stack_mem[stack_fill] = word;
                  stack_fill++;
               end else
                  st = ST_FULL;
            end
            REQ_POP: begin
               if (stack_fill > 0) stack_fill--;
               else st = ST_EMPTY;
            end
            REQ_ENQUEUE: begin
               if (!queue_put(word)) st = ST_FULL;
            end
            REQ_DEQUEUE: begin
               if (queue_fill > 0) begin
                  queue_head = (queue_head + 1) % QUEUE_DEPTH_DEF;
                  queue_fill--;
               end else
                  st = ST_EMPTY;
            end
            REQ_POUR: begin
               // top of stack goes first; stops once the queue is full
               while (stack_fill > 0 && st == ST_OK) begin
                  if (queue_put(stack_mem[stack_fill - 1])) stack_fill--;
                  else st = ST_FULL;
               end
            end
            default: ;
         endcase
         await_rsp('0, 1'b1, st);
      end
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         stack_fill = 0;
         queue_fill = 0;
         queue_head = 0;
         awaited_rsp.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen++;
            if (awaited_rsp.size() == 0) begin
               errs++;
               $error("response transfer with nothing awaited: word_out %h last %b status %0d",
                      rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_tdata !== want.word) begin
                  errs++;
                  $error("word_out: expected %h, got %h", want.word, rsp_tdata);
               end
               if (rsp_tlast !== want.last) begin
                  errs++;
                  $error("last: expected %b, got %b", want.last, rsp_tlast);
               end
               if (rsp_tuser !== want.status) begin
                  errs++;
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               end
            end
         end
         if (req_tvalid && req_tready)
            apply_request(req_tuser, req_tdata);
      end
      pending <= awaited_rsp.size();
   end

endmodule

// File: verif/tb_stack_queue_transfer_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stack_queue_transfer_engine
// Drives push, pop, enqueue, dequeue, pour, dump and unused request codes
// into the engine: a directed opening over empty stores and extreme words,
// then bursts that fill and drain both stores mixed with single random
// requests. Both streams idle at random, then neither; the shadow checker judges.
// ----------------------------------------------------------------------------
module tb_stack_queue_transfer_engine
   import sqte_pkg::*;
();

   localparam int RANDOM_ITEMS = 200;
   localparam int PLAN_ITEMS   = RANDOM_ITEMS + 20;
   localparam int CYCLE_LIMIT  = 400000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;

   int fail_count;
   int pending;
   int rsp_seen;
   int cycle_count = 0;
   int sent_total  = 0;
   int idle_phase  = 0;
   int kind_count [8];

   always #1 clock = ~clock;

   stack_queue_transfer_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   sqte_shadow_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending),
      .rsp_seen   (rsp_seen)
   );

   // sender idles 34 then 67 per cent, receiver the reverse, then neither
   always @(posedge clock) begin
      case (idle_phase)
         0:       rsp_tready <= $urandom_range(0, 99) >= 67;
         1:       rsp_tready <= $urandom_range(0, 99) >= 34;
         default: rsp_tready <= 1'b1;
      endcase
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_stack_queue_transfer_engine: errors");
         $finish;
      end
   end

   task automatic send(input logic [2:0] kind, input logic [31:0] word);
      int idle_pct;
      idle_phase = (sent_total * 3) / PLAN_ITEMS;
      if (idle_phase > 2) idle_phase = 2;
      idle_pct = (idle_phase == 0) ? 34 : (idle_phase == 1) ? 67 : 0;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      kind_count[kind]++;
      sent_total++;
   endtask

   initial begin
      int mode;
      int burst;
      int random_start;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty stores first
      send(REQ_DUMP, 32'h0);
      send(REQ_POP, 32'hffff_ffff);
      send(REQ_DEQUEUE, 32'hffff_ffff);
      send(REQ_POUR, 32'h0);
      // extreme words through stack, pour and queue
      send(REQ_PUSH, 32'h8000_0000);
      send(REQ_PUSH, 32'h7fff_ffff);
      send(REQ_PUSH, 32'h0000_0000);
      send(REQ_PUSH, 32'hffff_ffff);
      send(REQ_ENQUEUE, 32'haaaa_aaaa);
      send(REQ_ENQUEUE, 32'h5555_5555);
      send(REQ_DUMP, 32'h0);
      send(REQ_POP, 32'h0);
      send(REQ_POUR, 32'h1234_5678);
      send(REQ_DUMP, 32'h0);
      send(REQ_DEQUEUE, 32'h0);
      send(REQ_DEQUEUE, 32'h0);
      send(3'd6, 32'hdead_beef);
      send(3'd7, 32'h0bad_f00d);
      send(REQ_DUMP, 32'h0);
      send(REQ_POUR, 32'h0);

      // bursts to reach full and empty on both stores, plus single requests
      random_start = sent_total;
      while (sent_total - random_start < RANDOM_ITEMS) begin
         mode  = $urandom_range(0, 9);
         burst = $urandom_range(4, 36);
         case (mode)
            0:       for (int i = 0; i < burst; i++) send(REQ_PUSH, $urandom);
            1:       for (int i = 0; i < burst; i++) send(REQ_ENQUEUE, $urandom);
            2:       for (int i = 0; i < burst / 3; i++) send(REQ_POP, $urandom);
            3:       for (int i = 0; i < burst / 3; i++) send(REQ_DEQUEUE, $urandom);
            4:       send(REQ_POUR, $urandom);
            5:       send(REQ_DUMP, $urandom);
            default: send(3'($urandom_range(0, 7)), $urandom);
         endcase
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("requests sent: %0d push, %0d pop, %0d enqueue, %0d dequeue, %0d pour, %0d dump",
               kind_count[REQ_PUSH], kind_count[REQ_POP], kind_count[REQ_ENQUEUE],
               kind_count[REQ_DEQUEUE], kind_count[REQ_POUR], kind_count[REQ_DUMP]);
      $display("unused codes: %0d; response transfers checked: %0d",
               kind_count[6] + kind_count[7], rsp_seen);
      if (fail_count == 0)
         $display("tb_stack_queue_transfer_engine: clean");
      else
         $display("tb_stack_queue_transfer_engine: errors");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/sqte_pkg.sv
sv/sqte_ram.sv
sv/sqte_ctrl.sv
sv/sqte_dp.sv
sv/stack_queue_transfer_engine.sv
sv/sqte_checker.sv
verif/sqte_shadow_checker.sv
verif/tb_stack_queue_transfer_engine.sv
